// ----- hw/rtl/shup_pkg.sv -----
package shup_pkg;

  // Longest run of prefix zeros that an Exp-Golomb code may carry.
  localparam int unsigned MAX_PREFIX_ZEROS = 31;

  localparam logic [4:0] NAL_TYPE_SLICE = 5'd1;
  localparam logic [4:0] NAL_TYPE_IDR   = 5'd5;

  localparam logic [31:0] SLICE_KIND_LIMIT  = 32'd4;
  localparam logic [31:0] SLICE_KIND_OFFSET = 32'd5;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_MB   = 4'b0010,
    PH_TYPE = 4'b0100,
    PH_PPS  = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic        in_suffix;
    logic [5:0]  zero_count;
    logic [5:0]  suffix_left;
    logic [31:0] suffix_accum;
    logic [4:0]  nal_type;
    logic [31:0] first_mb;
    logic [31:0] coded_type;
  } state_t;

  typedef struct packed {
    logic [4:0]  nal_type;
    logic        is_slice;
    logic [31:0] first_mb;
    logic [31:0] raw_slice_type;
    logic [31:0] param_set_id;
    logic        prefix_error;
  } result_t;

  localparam state_t STATE_RESET = '{phase: PH_IDLE, default: '0};

endpackage

// ----- hw/rtl/h264_slice_header_ue_parser_top.sv -----
// Channel   Ports                                              Direction
// input     in_valid, in_ready, in_data_byte, in_first_byte     in
// result    out_valid, out_ready, out_nal_type, out_is_slice,   out
//           out_first_macroblock, out_raw_slice_type,
//           out_slice_kind, out_param_set_id, out_prefix_error
//
// One byte is taken every cycle while in_ready is high; all eight bits are decoded in one pass
// between the input register and the result register, which a result passes through in turn.
// Reset (synchronous, rst_n low) closes any open unit and empties both registers.
// While a result waits on out_ready, one more request is still taken into the input
// register; further requests are held off until the result leaves.
module h264_slice_header_ue_parser_top #(
  parameter int unsigned MAX_PREFIX_ZEROS = shup_pkg::MAX_PREFIX_ZEROS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_nal_type,
  output logic        out_is_slice,
  output logic [31:0] out_first_macroblock,
  output logic [31:0] out_raw_slice_type,
  output logic [31:0] out_slice_kind,
  output logic [31:0] out_param_set_id,
  output logic        out_prefix_error
);

  logic              in_vld_r;
  logic              in_vld_nxt;
  logic [7:0]        byte_r;
  logic              first_r;
  logic              out_free;
  logic              adv;
  logic              res_vld;
  shup_pkg::result_t res;
  shup_pkg::state_t  st_r;
  shup_pkg::state_t  st_nxt;

  assign adv        = in_vld_r && out_free;
  assign in_ready   = !in_vld_r || out_free;
  assign in_vld_nxt = (in_valid && in_ready) || (in_vld_r && !out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      st_r     <= shup_pkg::STATE_RESET;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r  <= in_data_byte;
      first_r <= in_first_byte;
    end
  end

  shup_byte_dec #(
    .MAX_PREFIX_ZEROS (MAX_PREFIX_ZEROS)
  ) u_dec (
    .byte_i    (byte_r),
    .first_i   (first_r),
    .st_i      (st_r),
    .st_o      (st_nxt),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  shup_out_reg u_out (
    .clk                  (clk),
    .rst_n                (rst_n),
    .load_i               (adv && res_vld),
    .res_i                (res),
    .out_ready            (out_ready),
    .free_o               (out_free),
    .out_valid            (out_valid),
    .out_nal_type         (out_nal_type),
    .out_is_slice         (out_is_slice),
    .out_first_macroblock (out_first_macroblock),
    .out_raw_slice_type   (out_raw_slice_type),
    .out_slice_kind       (out_slice_kind),
    .out_param_set_id     (out_param_set_id),
    .out_prefix_error     (out_prefix_error)
  );

endmodule

// ----- hw/rtl/shup_byte_dec.sv -----
module shup_byte_dec #(
  parameter int unsigned MAX_PREFIX_ZEROS = shup_pkg::MAX_PREFIX_ZEROS
) (
  input  logic [7:0]       byte_i,
  input  logic             first_i,
  input  shup_pkg::state_t st_i,
  output shup_pkg::state_t st_o,
  output logic             res_vld_o,
  output shup_pkg::result_t res_o
);

  shup_pkg::state_t  s;
  shup_pkg::result_t r;
  logic              done;
  logic [31:0]       value;

  always_comb begin
    s     = st_i;
    r     = '0;
    done  = 1'b0;
    value = '0;
    if (first_i) begin
      s = shup_pkg::STATE_RESET;
      s.nal_type = byte_i[4:0];
      if (byte_i[4:0] == shup_pkg::NAL_TYPE_SLICE || byte_i[4:0] == shup_pkg::NAL_TYPE_IDR) begin
        s.phase = shup_pkg::PH_MB;
      end else begin
        done       = 1'b1;
        r.nal_type = byte_i[4:0];
      end
    end else begin
      // Eight bit steps, most significant bit first; a finished unit stops the walk.
      for (int k = 7; k >= 0; k--) begin
        if (!done && s.phase != shup_pkg::PH_IDLE) begin
          if (!s.in_suffix) begin
            if (!byte_i[k]) begin
              if (s.zero_count == 6'(MAX_PREFIX_ZEROS)) begin
                done           = 1'b1;
                r.nal_type     = s.nal_type;
                r.prefix_error = 1'b1;
                s.phase        = shup_pkg::PH_IDLE;
                s.zero_count   = '0;
              end else begin
                s.zero_count = s.zero_count + 6'd1;
              end
            end else if (s.zero_count == 6'd0) begin
              unique case (s.phase)
                shup_pkg::PH_MB: begin
                  s.first_mb = '0;
                  s.phase    = shup_pkg::PH_TYPE;
                end
                shup_pkg::PH_TYPE: begin
                  s.coded_type = '0;
                  s.phase      = shup_pkg::PH_PPS;
                end
                default: begin
                  done             = 1'b1;
                  r.nal_type       = s.nal_type;
                  r.is_slice       = 1'b1;
                  r.first_mb       = s.first_mb;
                  r.raw_slice_type = s.coded_type;
                  r.param_set_id   = '0;
                  s.phase          = shup_pkg::PH_IDLE;
                end
              endcase
            end else begin
              s.in_suffix    = 1'b1;
              s.suffix_left  = s.zero_count;
              s.suffix_accum = '0;
            end
          end else begin
            s.suffix_accum = {s.suffix_accum[30:0], byte_i[k]};
            s.suffix_left  = s.suffix_left - 6'd1;
            if (s.suffix_left == 6'd0) begin
              // The suffix is narrower than the prefix weight, so an OR replaces the add.
              value = ((32'd1 << s.zero_count) | s.suffix_accum) - 32'd1;
              s.in_suffix    = 1'b0;
              s.zero_count   = '0;
              s.suffix_accum = '0;
              unique case (s.phase)
                shup_pkg::PH_MB: begin
                  s.first_mb = value;
                  s.phase    = shup_pkg::PH_TYPE;
                end
                shup_pkg::PH_TYPE: begin
                  s.coded_type = value;
                  s.phase      = shup_pkg::PH_PPS;
                end
                default: begin
                  done             = 1'b1;
                  r.nal_type       = s.nal_type;
                  r.is_slice       = 1'b1;
                  r.first_mb       = s.first_mb;
                  r.raw_slice_type = s.coded_type;
                  r.param_set_id   = value;
                  s.phase          = shup_pkg::PH_IDLE;
                end
              endcase
            end
          end
        end
      end
    end
    st_o      = s;
    res_o     = r;
    res_vld_o = done;
  end

endmodule

// ----- hw/rtl/shup_out_reg.sv -----
module shup_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_i,
  input  shup_pkg::result_t res_i,
  input  logic              out_ready,
  output logic              free_o,
  output logic              out_valid,
  output logic [4:0]        out_nal_type,
  output logic              out_is_slice,
  output logic [31:0]       out_first_macroblock,
  output logic [31:0]       out_raw_slice_type,
  output logic [31:0]       out_slice_kind,
  output logic [31:0]       out_param_set_id,
  output logic              out_prefix_error
);

  logic              vld_r;
  logic              vld_nxt;
  shup_pkg::result_t res_r;

  assign free_o  = !vld_r || out_ready;
  assign vld_nxt = load_i || (vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= res_i;
    end
  end

  assign out_valid            = vld_r;
  assign out_nal_type         = res_r.nal_type;
  assign out_is_slice         = res_r.is_slice;
  assign out_first_macroblock = res_r.first_mb;
  assign out_raw_slice_type   = res_r.raw_slice_type;
  assign out_param_set_id     = res_r.param_set_id;
  assign out_prefix_error     = res_r.prefix_error;
  assign out_slice_kind       = (res_r.raw_slice_type > shup_pkg::SLICE_KIND_LIMIT) ?
                                (res_r.raw_slice_type - shup_pkg::SLICE_KIND_OFFSET) :
                                res_r.raw_slice_type;

endmodule

// ----- hw/rtl/shup_checker.sv -----
module shup_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_data_byte,
  input logic        in_first_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_nal_type,
  input logic        out_is_slice,
  input logic [31:0] out_first_macroblock,
  input logic [31:0] out_raw_slice_type,
  input logic [31:0] out_slice_kind,
  input logic [31:0] out_param_set_id,
  input logic        out_prefix_error
);

  // A waiting result must not be withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  a_slice_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_slice |-> !out_prefix_error)
    else $error("slice result flagged with a prefix error");

  a_slice_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_slice |->
      (out_nal_type == shup_pkg::NAL_TYPE_SLICE || out_nal_type == shup_pkg::NAL_TYPE_IDR))
    else $error("slice result from a unit that is not a slice");

  a_not_slice_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_slice |->
      out_first_macroblock == 32'd0 && out_raw_slice_type == 32'd0 &&
      out_slice_kind == 32'd0 && out_param_set_id == 32'd0)
    else $error("non-slice result carries decoded fields");

endmodule

bind h264_slice_header_ue_parser_top shup_checker u_shup_checker (.*);

// ----- sim/h264_slice_header_ue_parser_top_tb.sv -----
module h264_slice_header_ue_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BYTES_WANTED     = 1500;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 8;
  localparam int WATCHDOG_LIMIT   = 3000;

  typedef struct packed {
    logic [4:0]  nal_type;
    logic        is_slice;
    logic [31:0] first_mb;
    logic [31:0] raw_type;
    logic [31:0] kind;
    logic [31:0] pps_id;
    logic        prefix_error;
  } slice_header_t;

  class slice_header_scoreboard;
    shup_pkg::phase_t phase;
    bit               in_suffix;
    int unsigned      zeros;
    int unsigned      suffix_left;
    logic [31:0]      accum;
    logic [4:0]       nal;
    logic [31:0]      held_mb;
    logic [31:0]      held_type;
    slice_header_t    expected_headers[$];
    int unsigned      mismatches;
    int unsigned      headers_checked;
    int unsigned      slices_seen;
    int unsigned      overruns_seen;

    function new();
      phase = shup_pkg::PH_IDLE;
      clear_code();
      nal = '0;
      held_mb = '0;
      held_type = '0;
      mismatches = 0;
      headers_checked = 0;
      slices_seen = 0;
      overruns_seen = 0;
    endfunction

    function void clear_code();
      in_suffix = 1'b0;
      zeros = 0;
      suffix_left = 0;
      accum = '0;
    endfunction

    function void queue_header(logic slice, logic [31:0] mb, logic [31:0] st,
                               logic [31:0] pps, logic err);
      slice_header_t h;
      h.nal_type = nal;
      h.is_slice = slice;
      h.first_mb = mb;
      h.raw_type = st;
      h.kind = (st > shup_pkg::SLICE_KIND_LIMIT) ? st - shup_pkg::SLICE_KIND_OFFSET : st;
      h.pps_id = pps;
      h.prefix_error = err;
      expected_headers.push_back(h);
    endfunction

    // Returns 1 when the third code completes and a header is due.
    function bit store_code(logic [31:0] value);
      clear_code();
      if (phase == shup_pkg::PH_MB) begin
        held_mb = value;
        phase = shup_pkg::PH_TYPE;
        return 1'b0;
      end
      if (phase == shup_pkg::PH_TYPE) begin
        held_type = value;
        phase = shup_pkg::PH_PPS;
        return 1'b0;
      end
      phase = shup_pkg::PH_IDLE;
      queue_header(1'b1, held_mb, held_type, value, 1'b0);
      return 1'b1;
    endfunction

    // Notes an accepted request; returns 0 when the byte is simply ignored.
    function bit decode_byte(logic [7:0] data, logic first);
      int k;
      logic cur;
      bit done;
      if (first) begin
        nal = data[4:0];
        held_mb = '0;
        held_type = '0;
        clear_code();
        if (nal == shup_pkg::NAL_TYPE_SLICE || nal == shup_pkg::NAL_TYPE_IDR) begin
          phase = shup_pkg::PH_MB;
        end else begin
          phase = shup_pkg::PH_IDLE;
          queue_header(1'b0, '0, '0, '0, 1'b0);
        end
        return 1'b1;
      end
      if (phase == shup_pkg::PH_IDLE) return 1'b0;
      done = 1'b0;
      for (k = 7; k >= 0 && !done; k--) begin
        cur = data[k];
        if (!in_suffix) begin
          if (!cur) begin
            zeros++;
            if (zeros > shup_pkg::MAX_PREFIX_ZEROS) begin
              phase = shup_pkg::PH_IDLE;
              clear_code();
              queue_header(1'b0, '0, '0, '0, 1'b1);
              done = 1'b1;
            end
          end else if (zeros == 0) begin
            done = store_code(32'd0);
          end else begin
            in_suffix = 1'b1;
            suffix_left = zeros;
            accum = '0;
          end
        end else begin
          accum = {accum[30:0], cur};
          suffix_left--;
          if (suffix_left == 0) done = store_code(((32'd1 << zeros) - 32'd1) + accum);
        end
      end
      return 1'b1;
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns: MISMATCH %s", $time, msg);
      mismatches++;
    endtask

    task check_header(slice_header_t got);
      slice_header_t want;
      if (expected_headers.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: nal_type %0d is_slice %0b",
                                  got.nal_type, got.is_slice));
        return;
      end
      want = expected_headers.pop_front();
      headers_checked++;
      if (want.is_slice) slices_seen++;
      if (want.prefix_error) overruns_seen++;
      if (got.nal_type !== want.nal_type)
        report_mismatch($sformatf("nal_type want %0d got %0d", want.nal_type, got.nal_type));
      if (got.is_slice !== want.is_slice)
        report_mismatch($sformatf("is_slice want %0b got %0b", want.is_slice, got.is_slice));
      if (got.first_mb !== want.first_mb)
        report_mismatch($sformatf("first_macroblock want %0d got %0d",
                                  want.first_mb, got.first_mb));
      if (got.raw_type !== want.raw_type)
        report_mismatch($sformatf("raw_slice_type want %0d got %0d",
                                  want.raw_type, got.raw_type));
      if (got.kind !== want.kind)
        report_mismatch($sformatf("slice_kind want %0d got %0d", want.kind, got.kind));
      if (got.pps_id !== want.pps_id)
        report_mismatch($sformatf("param_set_id want %0d got %0d", want.pps_id, got.pps_id));
      if (got.prefix_error !== want.prefix_error)
        report_mismatch($sformatf("prefix_error want %0b got %0b",
                                  want.prefix_error, got.prefix_error));
    endtask

    task close_out();
      if (expected_headers.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", expected_headers.size()));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_first_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_nal_type;
  logic        out_is_slice;
  logic [31:0] out_first_macroblock;
  logic [31:0] out_raw_slice_type;
  logic [31:0] out_slice_kind;
  logic [31:0] out_param_set_id;
  logic        out_prefix_error;

  slice_header_scoreboard headers = new();
  bit          code_bits[$];
  bit          hold_sink = 1'b0;
  bit          source_steady = 1'b0;
  int unsigned bytes_accepted = 0;
  int unsigned decoded_bytes = 0;

  h264_slice_header_ue_parser_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data_byte         (in_data_byte),
    .in_first_byte        (in_first_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_nal_type         (out_nal_type),
    .out_is_slice         (out_is_slice),
    .out_first_macroblock (out_first_macroblock),
    .out_raw_slice_type   (out_raw_slice_type),
    .out_slice_kind       (out_slice_kind),
    .out_param_set_id     (out_param_set_id),
    .out_prefix_error     (out_prefix_error)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_code();
    int r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(0, 9);
    if (r < 75) return $urandom_range(0, 300);
    if (r < 95) begin
      v = $urandom >> $urandom_range(0, 31);
      return (v == 32'hFFFFFFFF) ? 32'hFFFFFFFE : v;
    end
    return 32'hFFFFFFFE - $urandom_range(0, 2);
  endfunction

  function automatic void append_ue(logic [31:0] value);
    logic [32:0] w;
    int n;
    int i;
    w = {1'b0, value} + 33'd1;
    n = 32;
    while (n > 0 && !w[n]) n--;
    for (i = 0; i < n; i++) code_bits.push_back(1'b0);
    for (i = n; i >= 0; i--) code_bits.push_back(w[i]);
  endfunction

  function automatic void append_slice_codes();
    append_ue(pick_code());
    append_ue(($urandom_range(0, 9) < 7) ? 32'($urandom_range(0, 9)) : pick_code());
    append_ue(pick_code());
  endfunction

  function automatic logic [7:0] slice_header();
    return {3'($urandom),
            ($urandom_range(0, 1) == 1) ? shup_pkg::NAL_TYPE_IDR : shup_pkg::NAL_TYPE_SLICE};
  endfunction

  task automatic idle_source(int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_data_byte = 8'($urandom);
      in_first_byte = 1'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic push_byte(logic [7:0] data, logic first);
    @(negedge clk);
    in_valid = 1'b1;
    in_data_byte = data;
    in_first_byte = first;
    do @(posedge clk); while (!in_ready);
    bytes_accepted++;
    if (headers.decode_byte(data, first)) decoded_bytes++;
    idle_source(pick_gap(source_steady));
  endtask

  // Sends a header byte, then up to keep bytes of the packed code bits, then
  // trailing bytes of random content.
  task automatic send_unit(logic [7:0] header, int keep, int trailing);
    int i;
    int j;
    int total;
    logic [7:0] data;
    push_byte(header, 1'b1);
    while (code_bits.size() % 8 != 0) code_bits.push_back(1'($urandom));
    total = code_bits.size() / 8;
    if (keep > total) keep = total;
    for (i = 0; i < keep; i++) begin
      for (j = 0; j < 8; j++) data[7 - j] = code_bits[8 * i + j];
      push_byte(data, 1'b0);
    end
    for (i = 0; i < trailing; i++) push_byte(8'($urandom), 1'b0);
    code_bits.delete();
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (headers.expected_headers.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_unit();
    int r;
    int k;
    int cut;
    logic [4:0] t;
    r = $urandom_range(0, 99);
    source_steady = ($urandom_range(0, 9) == 0);
    code_bits.delete();
    if (r < 65) begin
      append_slice_codes();
      send_unit(slice_header(), 1000, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
    end else if (r < 77) begin
      do t = 5'($urandom_range(0, 31));
      while (t == shup_pkg::NAL_TYPE_SLICE || t == shup_pkg::NAL_TYPE_IDR);
      send_unit({3'($urandom), t}, 0, $urandom_range(0, 3));
    end else if (r < 87) begin
      // A code whose run of leading zeros is too long, possibly after good codes.
      for (k = $urandom_range(0, 2); k > 0; k--) append_ue(pick_code());
      for (k = 32 + $urandom_range(0, 8); k > 0; k--) code_bits.push_back(1'b0);
      send_unit(slice_header(), 1000, 0);
    end else if (r < 95) begin
      // Cut short: the next header drops the open unit.
      append_slice_codes();
      cut = (code_bits.size() + 7) / 8;
      send_unit(slice_header(), $urandom_range(0, cut - 1), 0);
    end else begin
      send_unit(8'($urandom), 0, $urandom_range(1, 8));
    end
  endtask

  // Result side: sample at the rising edge, steer ready at the falling edge.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        headers.check_header('{out_nal_type, out_is_slice, out_first_macroblock,
                               out_raw_slice_type, out_slice_kind, out_param_set_id,
                               out_prefix_error});
    end
  end

  initial begin
    int high_left;
    int low_left;
    high_left = 0;
    low_left = 0;
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        out_ready = 1'b0;
        repeat (SINK_HOLD_CYCLES - 1) @(negedge clk);
        hold_sink = 1'b0;
      end else begin
        if (high_left == 0 && low_left == 0) begin
          if ($urandom_range(0, 9) == 0) begin
            high_left = $urandom_range(60, 150);
          end else begin
            high_left = $urandom_range(1, 8);
            low_left = pick_gap(1'b0);
          end
        end
        if (high_left > 0) begin
          out_ready = 1'b1;
          high_left--;
        end else begin
          out_ready = 1'b0;
          low_left--;
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    bit held;
    bit drained;
    held = 1'b0;
    drained = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: bytes with no unit open, other NAL types, shortest and
    // longest codes, an overlong prefix and a header arriving mid-unit.
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    send_unit(8'h00, 0, 0);
    send_unit(8'hFF, 0, 1);
    append_ue(32'd0);
    append_ue(32'd0);
    append_ue(32'd0);
    send_unit(8'h21, 1000, 0);
    append_ue(32'hFFFFFFFE);
    append_ue(32'd9);
    append_ue(32'd0);
    send_unit(8'h65, 1000, 0);
    repeat (32) code_bits.push_back(1'b0);
    send_unit(8'h45, 1000, 0);
    append_ue(32'h7FFFFFFF);
    append_ue(32'd2);
    append_ue(32'd1);
    send_unit(8'h01, 1, 0);
    append_ue(32'd3);
    append_ue(32'd5);
    append_ue(32'd31);
    send_unit(8'hE5, 1000, 0);

    while (bytes_accepted < BYTES_WANTED) begin
      if (!held && bytes_accepted >= BYTES_WANTED / 3) begin
        hold_sink = 1'b1;
        held = 1'b1;
      end
      if (!drained && bytes_accepted >= 2 * BYTES_WANTED / 3) begin
        wait_for_results();
        drained = 1'b1;
      end
      send_random_unit();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    headers.close_out();

    $display("Sent %0d bytes (%0d decoded); checked %0d results: %0d slices, %0d overruns.",
             bytes_accepted, decoded_bytes, headers.headers_checked, headers.slices_seen,
             headers.overruns_seen);
    $display("Result side held off for %0d cycles once; input paused once for a full drain.",
             SINK_HOLD_CYCLES);
    if (headers.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/shup_pkg.sv
hw/rtl/shup_byte_dec.sv
hw/rtl/shup_out_reg.sv
hw/rtl/h264_slice_header_ue_parser_top.sv
hw/rtl/shup_checker.sv
sim/h264_slice_header_ue_parser_top_tb.sv
